FILE: rtl/dle_stx_etx_frame_decoder_assert.svh
// Assertion helpers shared by the deframer modules.
// Each macro expects clk and arst_n in scope.
`ifndef DLE_STX_ETX_FRAME_DECODER_ASSERT_SVH
`define DLE_STX_ETX_FRAME_DECODER_ASSERT_SVH

// cond must hold at every edge out of reset
`define DSEFD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define DSEFD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define DSEFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dsefd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsefd_pkg;

	localparam int unsigned FRAME_BUFFER_BYTES = 512;

	localparam int BYTE_W    = 8;
	localparam int CNT_W     = 10;
	localparam int POS_W     = 9;
	localparam int STAT_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 10;

	localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h9F;
	localparam logic [BYTE_W-1:0] OPEN_BYTE  = 8'h02;
	localparam logic [BYTE_W-1:0] CLOSE_BYTE = 8'h03;

	localparam logic [CNT_W-1:0] BUF_MAX   = CNT_W'(FRAME_BUFFER_BYTES);
	localparam logic [CFG_W-1:0] MIN_RESET = CFG_W'(3);
	localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(512);

	localparam logic [CFG_IDX_W-1:0] REG_MIN_STORED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_STORED = CFG_IDX_W'(1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CLS_PLAIN,
		CLS_ESC,
		CLS_OPEN,
		CLS_CLOSE
	} byte_cls_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		byte_cls_t         cls;
	} q_item_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_OPEN,
		PH_DATA,
		PH_ESC
	} phase_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_CSUM,
		ST_LEN,
		ST_OVF,
		ST_ABORT
	} end_status_t;

	typedef struct packed {
		logic              is_end;
		logic [BYTE_W-1:0] payload;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  len;
		end_status_t       status;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/dsefd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module dsefd_front import dsefd_pkg::*; (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire q_status_t         q_status,
	output logic                   push,
	output q_item_t                push_item
);

	byte_cls_t cls;

	// tag the control bytes once so the back end only decodes a class
	always_comb begin
		case (rx_byte)
			ESC_BYTE:   cls = CLS_ESC;
			OPEN_BYTE:  cls = CLS_OPEN;
			CLOSE_BYTE: cls = CLS_CLOSE;
			default:    cls = CLS_PLAIN;
		endcase
	end

	assign in_stall       = q_status.full;
	assign push           = in_valid & ~q_status.full;
	assign push_item.data = rx_byte;
	assign push_item.cls  = cls;

endmodule

`default_nettype wire

FILE: rtl/dsefd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module dsefd_queue import dsefd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire q_item_t push_item,
	input  wire logic    pop,
	output q_item_t      head,
	output q_status_t    status
);

	q_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign head             = mem_q[rd_ptr_q];
	assign status.not_empty = (count_q != '0);
	assign status.full      = (count_q == QCNT_W'(QUEUE_DEPTH));

`include "dle_stx_etx_frame_decoder_assert.svh"

	`DSEFD_ASSERT_ALWAYS(a_q_count_bound, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
	`DSEFD_ASSERT_IMPL(a_q_no_underflow, pop, count_q != '0, "pop from empty queue")
	`DSEFD_ASSERT_NEXT(a_q_push_lands, push && !pop, count_q != '0, "pushed item lost")

endmodule

`default_nettype wire

FILE: rtl/dsefd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module dsefd_back import dsefd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire q_status_t            q_status,
	input  wire q_item_t              head,
	output logic                      pop,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output result_t                   out_res
);

	logic [CFG_W-1:0]  min_q;
	logic [CFG_W-1:0]  max_q;
	phase_t            phase_q;
	phase_t            phase_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [BYTE_W-1:0] held_q;
	logic [BYTE_W-1:0] held_d;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] xor_d;
	logic              out_valid_q;
	result_t           out_res_q;

	logic              res_valid;
	result_t           res;
	logic [CNT_W-1:0]  eff_max;
	logic [CNT_W-1:0]  min_lo;
	logic [CNT_W-1:0]  cnt_m1;
	logic              full_hit;
	end_status_t       close_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
			max_q <= MAX_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_MIN_STORED) begin
				min_q <= cfg_data;
			end
			if (cfg_index == REG_MAX_STORED) begin
				max_q <= cfg_data;
			end
		end
	end

	assign eff_max  = (max_q > BUF_MAX) ? BUF_MAX : max_q;
	assign min_lo   = (min_q == '0) ? CNT_W'(1) : min_q;
	assign full_hit = (cnt_q >= eff_max);
	assign cnt_m1   = cnt_q - CNT_W'(1);

	// length error wins over checksum error
	always_comb begin
		if (cnt_q < min_lo || cnt_q > eff_max) begin
			close_status = ST_LEN;
		end else if (held_q != xor_q) begin
			close_status = ST_CSUM;
		end else begin
			close_status = ST_OK;
		end
	end

	// take one item whenever the output slot is free or draining
	assign pop = q_status.not_empty & (~out_valid_q | ~out_stall);

	// next phase
	always_comb begin
		case (phase_q)
			PH_HUNT: begin
				phase_d = (head.cls == CLS_ESC) ? PH_OPEN : PH_HUNT;
			end
			PH_OPEN: begin
				phase_d = (head.cls == CLS_OPEN) ? PH_DATA : PH_HUNT;
			end
			PH_DATA: begin
				if (head.cls == CLS_ESC) begin
					phase_d = PH_ESC;
				end else begin
					phase_d = full_hit ? PH_HUNT : PH_DATA;
				end
			end
			PH_ESC: begin
				case (head.cls)
					CLS_ESC:  phase_d = full_hit ? PH_HUNT : PH_DATA;
					CLS_OPEN: phase_d = PH_DATA;
					default:  phase_d = PH_HUNT;
				endcase
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// results and frame bookkeeping
	always_comb begin
		logic        do_store;
		logic        do_end;
		end_status_t end_st;

		do_store  = 1'b0;
		do_end    = 1'b0;
		end_st    = ST_ABORT;
		res_valid = 1'b0;
		res       = '0;
		cnt_d     = cnt_q;
		held_d    = held_q;
		xor_d     = xor_q;

		case (phase_q)
			PH_OPEN: begin
				cnt_d  = '0;
				held_d = '0;
				xor_d  = '0;
			end
			PH_DATA: begin
				do_store = (head.cls != CLS_ESC);
			end
			PH_ESC: begin
				case (head.cls)
					CLS_ESC: begin
						do_store = 1'b1;
					end
					CLS_CLOSE: begin
						do_end = 1'b1;
						end_st = close_status;
					end
					default: begin
						do_end = 1'b1;
						end_st = ST_ABORT;
					end
				endcase
			end
			default: begin
				do_store = 1'b0;
			end
		endcase

		// no room left: drop the byte, close as overflow
		if (do_store && full_hit) begin
			do_store = 1'b0;
			do_end   = 1'b1;
			end_st   = ST_OVF;
		end

		if (do_store) begin
			if (cnt_q != '0) begin
				res_valid   = 1'b1;
				res.payload = held_q;
				res.pos     = cnt_m1[POS_W-1:0];
				xor_d       = xor_q ^ held_q;
			end
			held_d = head.data;
			cnt_d  = cnt_q + CNT_W'(1);
		end

		if (do_end) begin
			res_valid  = 1'b1;
			res.is_end = 1'b1;
			res.len    = (cnt_q == '0) ? '0 : cnt_m1[POS_W-1:0];
			res.status = end_st;
			cnt_d      = '0;
			held_d     = '0;
			xor_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			held_q  <= '0;
			xor_q   <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			held_q  <= held_d;
			xor_q   <= xor_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

`include "dle_stx_etx_frame_decoder_assert.svh"

	`DSEFD_ASSERT_IMPL(a_hunt_empty, phase_q == PH_HUNT, cnt_q == '0, "stale count while hunting")
	`DSEFD_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= BUF_MAX, "stored count past buffer size")
	`DSEFD_ASSERT_NEXT(a_end_clears, pop && res_valid && res.is_end, cnt_q == '0, "frame not cleared")

endmodule

`default_nettype wire

FILE: rtl/dle_stx_etx_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------------------
// in       | in_valid / in_stall        | rx_byte
// out      | out_valid / out_stall      | is_frame_end, payload_byte, byte_position,
//          |                            | frame_length, end_status
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall stays low; the deframing state updates
// once per item. An accepted item is written into the queue; the edge that pops it loads
// its result (if any) into the output register, which drives out_valid.
// in_stall rises only when the 4-entry queue is full; the queue absorbs out_stall, so
// input keeps flowing after the output stalls until the queue fills.
// Reset: async, active low; state goes to hunting, registers to min 3, max 512.
// cfg_ready is always high; writes take effect on the next edge.

module dle_stx_etx_frame_decoder import dsefd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      is_frame_end,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic [POS_W-1:0]          byte_position,
	output logic [POS_W-1:0]          frame_length,
	output logic [STAT_W-1:0]         end_status,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	q_status_t q_status;
	q_item_t   push_item;
	q_item_t   head;
	logic      push;
	logic      pop;
	result_t   out_res;

	// front end: classify incoming bytes, push into the queue
	dsefd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue between classification and the deframer
	dsefd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	// back end: deframing state machine, checksum, output register
	dsefd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (out_res)
	);

	assign is_frame_end  = out_res.is_end;
	assign payload_byte  = out_res.payload;
	assign byte_position = out_res.pos;
	assign frame_length  = out_res.len;
	assign end_status    = out_res.status;

endmodule

`default_nettype wire

FILE: bench/dle_stx_etx_frame_decoder_test.sv
`timescale 1ns / 1ps

module dle_stx_etx_frame_decoder_test;
	import dsefd_pkg::*;

	// Frame endings that the stimulus can build.
	typedef enum int {
		CLOSE_GOOD,     // correct checksum, then escape + close
		CLOSE_BAD_SUM,  // checksum off by a nonzero xor, then escape + close
		CLOSE_BAD_ESC,  // escape followed by an illegal code
		CLOSE_NONE      // left open; whatever follows decides its end
	} frame_close_t;

	typedef logic [BYTE_W-1:0] octet_q_t[$];

	localparam int unsigned LONG_HOLD    = 64;     // long output stall, cycles
	localparam int unsigned TAIL_CYCLES  = 16;     // covers input queue depth plus output register
	localparam int unsigned DRAIN_LIMIT  = 50000;  // cycles allowed for one phase to empty

	// DUT connections; every input is known from time zero.
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic [BYTE_W-1:0]    rx_byte   = '0;
	logic                 out_stall = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 is_frame_end;
	logic [BYTE_W-1:0]    payload_byte;
	logic [POS_W-1:0]     byte_position;
	logic [POS_W-1:0]     frame_length;
	logic [STAT_W-1:0]    end_status;
	logic                 cfg_ready;

	// Bytes waiting to be offered, and results the decoder still owes us.
	octet_q_t    pending_bytes;
	result_t     expected_results[$];
	int unsigned queued_total = 0;
	int          error_count  = 0;

	// Traffic shaping, changed by the stimulus only on falling edges.
	bit          send_gaps   = 1'b1;
	bit          recv_gaps   = 1'b1;
	int unsigned holds_asked = 0;

	// Driver and monitor private state.
	int unsigned send_wait;
	int unsigned recv_wait;
	int unsigned hold_left;
	int unsigned holds_done;

	// Shadow of the deframer: register copies plus the per-frame state.
	logic [CFG_W-1:0]  min_cfg    = MIN_RESET;
	logic [CFG_W-1:0]  max_cfg    = MAX_RESET;
	phase_t            rx_phase   = PH_HUNT;
	logic [CNT_W-1:0]  stored_cnt = '0;
	logic [BYTE_W-1:0] held       = '0;
	logic [BYTE_W-1:0] csum_acc   = '0;

	dle_stx_etx_frame_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_frame_end (is_frame_end),
		.payload_byte (payload_byte),
		.byte_position(byte_position),
		.frame_length (frame_length),
		.end_status   (end_status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Expected behavior
	// ------------------------------------------------------------------

	// Buffer bound actually in force: the register, clipped to the buffer.
	function automatic logic [CNT_W-1:0] buffer_limit();
		return (max_cfg > BUF_MAX) ? BUF_MAX : max_cfg;
	endfunction

	// End event for the open frame; the frame state is cleared afterwards.
	function automatic void close_frame(end_status_t st);
		result_t r;
		r        = '0;
		r.is_end = 1'b1;
		r.len    = (stored_cnt != '0) ? POS_W'(stored_cnt - 1'b1) : '0;
		r.status = st;
		expected_results.push_back(r);
		stored_cnt = '0;
		held       = '0;
		csum_acc   = '0;
	endfunction

	// One unstuffed byte into the frame. The previously held byte goes out,
	// so the final byte (the checksum) is never seen on the output.
	function automatic void store_data(logic [BYTE_W-1:0] b);
		result_t r;
		if (stored_cnt >= buffer_limit()) begin
			rx_phase = PH_HUNT;
			close_frame(ST_OVF);
			return;
		end
		if (stored_cnt != '0) begin
			r         = '0;
			r.payload = held;
			r.pos     = POS_W'(stored_cnt - 1'b1);
			expected_results.push_back(r);
			csum_acc ^= held;
		end
		held       = b;
		stored_cnt = stored_cnt + 1'b1;
		rx_phase   = PH_DATA;
	endfunction

	// Advance the shadow by one accepted byte.
	function automatic void deframe_byte(logic [BYTE_W-1:0] b);
		logic [CNT_W-1:0] lo;
		case (rx_phase)
		PH_HUNT: begin
			if (b == ESC_BYTE)
				rx_phase = PH_OPEN;
		end
		PH_OPEN: begin
			stored_cnt = '0;
			held       = '0;
			csum_acc   = '0;
			rx_phase   = (b == OPEN_BYTE) ? PH_DATA : PH_HUNT;
		end
		PH_DATA: begin
			if (b == ESC_BYTE)
				rx_phase = PH_ESC;
			else
				store_data(b);
		end
		default: begin
			if (b == ESC_BYTE) begin
				store_data(b);
			end else if (b == OPEN_BYTE) begin
				// restart: old frame aborted, new one open at once
				rx_phase = PH_DATA;
				close_frame(ST_ABORT);
			end else if (b == CLOSE_BYTE) begin
				rx_phase = PH_HUNT;
				// a zero minimum still rejects a frame with nothing stored
				lo = (min_cfg != '0) ? min_cfg : CNT_W'(1);
				if (stored_cnt < lo || stored_cnt > buffer_limit())
					close_frame(ST_LEN);
				else if (held != csum_acc)
					close_frame(ST_CSUM);
				else
					close_frame(ST_OK);
			end else begin
				rx_phase = PH_HUNT;
				close_frame(ST_ABORT);
			end
		end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Input driver: one byte per item, random gap drawn per item
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			rx_byte   <= '0;
			send_wait <= 0;
		end else begin
			if (in_valid && !in_stall)
				deframe_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (send_wait != 0) begin
					in_valid  <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending_bytes.size() != 0) begin
					in_valid  <= 1'b1;
					rx_byte   <= pending_bytes.pop_front();
					send_wait <= send_gaps ? $urandom_range(0, 7) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: checks each item, draws a stall after each one,
	// and runs the long hold-off when the stimulus asks for it
	// ------------------------------------------------------------------
	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int unsigned wait_n;
		result_t     want;
		if (!arst_n) begin
			out_stall  <= 1'b0;
			recv_wait  <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			wait_n = recv_wait;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected item: end=%0b byte=%0d pos=%0d len=%0d status=%0d",
						is_frame_end, payload_byte, byte_position, frame_length, end_status);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("is_frame_end", want.is_end, is_frame_end);
					compare_field("payload_byte", want.payload, payload_byte);
					compare_field("byte_position", want.pos, byte_position);
					compare_field("frame_length", want.len, frame_length);
					compare_field("end_status", want.status, end_status);
				end
				wait_n = recv_gaps ? $urandom_range(0, 7) : 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (holds_done != holds_asked) begin
				out_stall  <= 1'b1;
				hold_left  <= LONG_HOLD - 1;
				holds_done <= holds_asked;
			end else if (wait_n != 0) begin
				out_stall <= 1'b1;
				wait_n--;
			end else begin
				out_stall <= 1'b0;
			end
			recv_wait <= wait_n;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus building blocks
	// ------------------------------------------------------------------
	function automatic void queue_byte(logic [BYTE_W-1:0] b);
		pending_bytes.push_back(b);
		queued_total++;
	endfunction

	function automatic void queue_raw(octet_q_t list);
		foreach (list[i])
			queue_byte(list[i]);
	endfunction

	// Escape bytes inside a frame go out doubled.
	function automatic void queue_stuffed(logic [BYTE_W-1:0] b);
		queue_byte(b);
		if (b == ESC_BYTE)
			queue_byte(ESC_BYTE);
	endfunction

	// Any code after an escape that is neither escape, open nor close.
	function automatic logic [BYTE_W-1:0] pick_bad_escape();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom);
		while (b == ESC_BYTE || b == OPEN_BYTE || b == CLOSE_BYTE);
		return b;
	endfunction

	// Frame content leans on the control codes so stuffing gets exercised.
	function automatic logic [BYTE_W-1:0] pick_body_byte();
		case ($urandom_range(0, 7))
		0:       return ESC_BYTE;
		1:       return OPEN_BYTE;
		2:       return CLOSE_BYTE;
		default: return BYTE_W'($urandom);
		endcase
	endfunction

	function automatic void queue_frame(octet_q_t body, frame_close_t how);
		logic [BYTE_W-1:0] sum;
		sum = '0;
		queue_byte(ESC_BYTE);
		queue_byte(OPEN_BYTE);
		foreach (body[i]) begin
			queue_stuffed(body[i]);
			sum ^= body[i];
		end
		case (how)
		CLOSE_GOOD, CLOSE_BAD_SUM: begin
			queue_stuffed((how == CLOSE_GOOD) ? sum : sum ^ BYTE_W'($urandom_range(1, 255)));
			queue_byte(ESC_BYTE);
			queue_byte(CLOSE_BYTE);
		end
		CLOSE_BAD_ESC: begin
			queue_byte(ESC_BYTE);
			queue_byte(pick_bad_escape());
		end
		default: ;
		endcase
	endfunction

	// Mostly well-formed frames with random bodies; the rest are bad
	// checksums, bad escapes, frames cut by a restart, and line noise.
	function automatic void queue_random_traffic(int unsigned n_bytes, int unsigned longest);
		octet_q_t    body;
		int unsigned start;
		start = queued_total;
		while (queued_total - start < n_bytes) begin
			body.delete();
			repeat ($urandom_range(0, longest))
				body.push_back(pick_body_byte());
			case ($urandom_range(0, 9))
			0: queue_frame(body, CLOSE_BAD_SUM);
			1: queue_frame(body, CLOSE_BAD_ESC);
			2: queue_frame(body, CLOSE_NONE);
			3: begin
				repeat ($urandom_range(1, 6))
					queue_byte(pick_body_byte());
				queue_byte('0);
			end
			default: queue_frame(body, CLOSE_GOOD);
			endcase
		end
	endfunction

	// Wait until the sender is empty and every expected item has come,
	// then let bytes that produce no item clear the input queue.
	task automatic settle();
		int unsigned spin;
		spin = 0;
		while ((pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
				&& spin < DRAIN_LIMIT) begin
			@(negedge clk);
			spin++;
		end
		if (expected_results.size() != 0) begin
			$error("%0d expected items never arrived", expected_results.size());
			error_count++;
			expected_results.delete();
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(negedge clk);
		while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_MIN_STORED)
			min_cfg = value;
		else
			max_cfg = value;
		@(negedge clk);
	endtask

	task automatic set_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
		write_reg(REG_MIN_STORED, lo);
		write_reg(REG_MAX_STORED, hi);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		octet_q_t nothing;
		octet_q_t big_body;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, reset limits (3..512).
		// Broken opening pairs, including escape-escape, are all hunted past.
		queue_raw('{ESC_BYTE, 8'h00, ESC_BYTE, ESC_BYTE, OPEN_BYTE});
		// Frame cut by a restart, whose new frame is fine and carries a stuffed escape.
		queue_frame('{8'hAA}, CLOSE_NONE);
		queue_frame('{8'hFF, ESC_BYTE, 8'h00}, CLOSE_GOOD);
		// Checksum error, with open and close codes as plain data.
		queue_frame('{OPEN_BYTE, CLOSE_BYTE}, CLOSE_BAD_SUM);
		// Nothing stored at all: length error, length zero.
		queue_frame(nothing, CLOSE_NONE);
		queue_raw('{ESC_BYTE, CLOSE_BYTE});
		// Bad escape right after opening.
		queue_frame(nothing, CLOSE_BAD_ESC);
		settle();

		// Random traffic in three stretches with different idling.
		queue_random_traffic(30, 12);
		settle();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		queue_random_traffic(20, 12);
		settle();
		send_gaps = 1'b1;
		queue_random_traffic(20, 12);
		settle();

		// One stored byte at most: only empty-body frames can pass.
		recv_gaps = 1'b1;
		set_limits(10'd1, 10'd1);
		queue_random_traffic(15, 2);
		settle();

		// Zero limits: first data byte overflows, empty frames fail on length.
		set_limits(10'd0, 10'd0);
		queue_frame(nothing, CLOSE_NONE);
		queue_raw('{ESC_BYTE, CLOSE_BYTE});
		queue_random_traffic(10, 2);
		settle();

		// Maximum beyond the buffer clips to 512: all 512 body bytes are
		// stored, the checksum byte after them overflows. Bytes below the escape code only,
		// so the body carries no stuffing.
		set_limits(10'd512, 10'd1023);
		repeat (512)
			big_body.push_back(BYTE_W'($urandom_range(0, 8'h9E)));
		queue_frame(big_body, CLOSE_GOOD);
		settle();

		// Minimum above maximum: every closed frame is a length error.
		set_limits(10'd1023, 10'd20);
		queue_random_traffic(20, 24);
		settle();

		// Long output hold while input keeps coming, so the input stalls.
		set_limits(10'd2, 10'd512);
		send_gaps = 1'b0;
		holds_asked++;
		big_body.delete();
		repeat (60)
			big_body.push_back(pick_body_byte());
		queue_frame(big_body, CLOSE_GOOD);
		settle();

		// Tight window for the bulk of the random run.
		send_gaps = 1'b1;
		set_limits(10'd2, 10'd16);
		queue_random_traffic(80, 20);
		settle();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
